FILE: rtl/ckb_pkg.sv
// Shared types and constants for the clipped color-key blitter.
// Used by the configuration register block and the top level.
`default_nettype none

package ckb_pkg;

	localparam int REG_W       = 13;
	localparam int KEY_W       = 25;
	localparam int CFG_DATA_W  = 25;
	localparam int CFG_INDEX_W = 3;
	localparam int RGB_W       = 24;

	localparam logic [7:0]       ALPHA_OPAQUE      = 8'hFF;
	localparam logic [KEY_W-1:0] KEY_OFF           = 25'h100_0000;
	localparam logic [REG_W-1:0] RST_IMAGE_WIDTH   = 13'd1;
	localparam logic [REG_W-1:0] RST_IMAGE_HEIGHT  = 13'd1;
	localparam logic [REG_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [REG_W-1:0] RST_SCREEN_HEIGHT = 13'd480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_IMAGE_WIDTH   = 3'd2,
		REG_IMAGE_HEIGHT  = 3'd3,
		REG_SCREEN_WIDTH  = 3'd4,
		REG_SCREEN_HEIGHT = 3'd5,
		REG_KEY_COLOR     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [REG_W-1:0] dest_x;
		logic signed [REG_W-1:0] dest_y;
		logic [REG_W-1:0]        image_width;
		logic [REG_W-1:0]        image_height;
		logic [REG_W-1:0]        screen_width;
		logic [REG_W-1:0]        screen_height;
		logic [KEY_W-1:0]        key_color;
	} ckb_regs_t;

endpackage

`default_nettype wire

FILE: rtl/ckb_pixel_if.sv
// Source pixel channel: valid/ready handshake carrying one RGB888 pixel.
// Stands alone; no package needed.
`default_nettype none

interface ckb_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/ckb_write_if.sv
// Framebuffer write channel: valid/ready handshake carrying one write request.
// Coordinate width follows COORD_BITS; no package needed.
`default_nettype none

interface ckb_write_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  write_valid;
	logic [COORD_BITS-1:0] screen_x;
	logic [COORD_BITS-1:0] screen_y;
	logic [31:0]           argb;
	logic                  image_done;

	modport source (output valid, output write_valid, output screen_x, output screen_y,
		output argb, output image_done, input ready);
	modport sink (input valid, input write_valid, input screen_x, input screen_y,
		input argb, input image_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/ckb_config.sv
// Configuration register file of the blitter: decodes indexed writes.
// Depends on ckb_pkg for register codes, reset values and the register struct.
`default_nettype none

module ckb_config (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write_en,
	input  wire logic [ckb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ckb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ckb_pkg::ckb_regs_t                  regs
);
	import ckb_pkg::*;

	ckb_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.dest_x        <= '0;
			regs_q.dest_y        <= '0;
			regs_q.image_width   <= RST_IMAGE_WIDTH;
			regs_q.image_height  <= RST_IMAGE_HEIGHT;
			regs_q.screen_width  <= RST_SCREEN_WIDTH;
			regs_q.screen_height <= RST_SCREEN_HEIGHT;
			regs_q.key_color     <= KEY_OFF;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEST_X:        regs_q.dest_x        <= signed'(cfg_data[REG_W-1:0]);
				REG_DEST_Y:        regs_q.dest_y        <= signed'(cfg_data[REG_W-1:0]);
				REG_IMAGE_WIDTH:   regs_q.image_width   <= cfg_data[REG_W-1:0];
				REG_IMAGE_HEIGHT:  regs_q.image_height  <= cfg_data[REG_W-1:0];
				REG_SCREEN_WIDTH:  regs_q.screen_width  <= cfg_data[REG_W-1:0];
				REG_SCREEN_HEIGHT: regs_q.screen_height <= cfg_data[REG_W-1:0];
				REG_KEY_COLOR:     regs_q.key_color     <= cfg_data[KEY_W-1:0];
				default: begin
					// Unused index: the write is dropped.
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

FILE: rtl/clipped_color_key_blit.sv
// Clipped color-key blitter: one source pixel in, one framebuffer write request out.
// A pixel passes the pixel register, then the result register. Throughput is one
// pixel per clock while not stalled; the position counters and the two-register
// pipeline (pixel register, result register) let a new pixel enter every cycle.
// Reset clears the counters and valid flags and loads the register defaults.
// Depends on ckb_pkg, ckb_pixel_if, ckb_write_if and ckb_config.
`default_nettype none

module clipped_color_key_blit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ckb_pixel_if.sink                            pixel,
	ckb_write_if.source                          blit,
	input  wire logic                            cfg_write_en,
	input  wire logic [ckb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ckb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ckb_pkg::*;

	// SZ_W holds a 13-bit register value as well as the limit 2^COORD_BITS.
	// PW holds the signed sum of a 13-bit origin and a COORD_BITS counter.
	localparam int SZ_W = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;
	localparam int PW   = ((COORD_BITS > REG_W - 1) ? COORD_BITS : REG_W - 1) + 2;
	localparam logic [SZ_W-1:0] LIMIT = SZ_W'(1) << COORD_BITS;

	ckb_regs_t regs;

	ckb_config u_config (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.regs         (regs)
	);

	// Derived bounds. Image sizes are saturated to 1 .. 2^COORD_BITS and the
	// clip bounds to 2^COORD_BITS, so every written coordinate fits the port.
	logic [SZ_W-1:0]       img_w, img_h, scr_w, scr_h;
	logic [SZ_W-1:0]       img_w_ext, img_h_ext, scr_w_ext, scr_h_ext;
	logic [COORD_BITS-1:0] last_col, last_row;

	always_comb begin
		img_w_ext = SZ_W'(regs.image_width);
		img_h_ext = SZ_W'(regs.image_height);
		scr_w_ext = SZ_W'(regs.screen_width);
		scr_h_ext = SZ_W'(regs.screen_height);
		if (img_w_ext == '0)
			img_w = SZ_W'(1);
		else
			img_w = (img_w_ext > LIMIT) ? LIMIT : img_w_ext;
		if (img_h_ext == '0)
			img_h = SZ_W'(1);
		else
			img_h = (img_h_ext > LIMIT) ? LIMIT : img_h_ext;
		scr_w    = (scr_w_ext > LIMIT) ? LIMIT : scr_w_ext;
		scr_h    = (scr_h_ext > LIMIT) ? LIMIT : scr_h_ext;
		last_col = COORD_BITS'(img_w - SZ_W'(1));
		last_row = COORD_BITS'(img_h - SZ_W'(1));
	end

	// Handshake. The result register frees up when it is empty or being taken;
	// the pixel register frees up when it is empty or moving on. Both can move
	// in the same cycle, so back-to-back pixels stream without bubbles.
	logic valid_s1, out_valid_q;
	logic out_free, s1_free, advance, pix_accept;

	assign out_free    = !out_valid_q || blit.ready;
	assign advance     = valid_s1 && out_free;
	assign s1_free     = !valid_s1 || out_free;
	assign pixel.ready = s1_free;
	assign pix_accept  = pixel.valid && s1_free;

	// Position counters advance on every accepted pixel. A column at or past
	// the last one ends the row, and a row at or past the last ends the image,
	// which keeps them sane if the size is rewritten mid-image.
	logic [COORD_BITS-1:0] col_q, row_q;
	logic                  row_end, img_end;

	assign row_end = col_q >= last_col;
	assign img_end = row_end && (row_q >= last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pix_accept) begin
				if (img_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (pix_accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (blit.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Pixel register: color plus the position it was taken at.
	logic [RGB_W-1:0]      rgb_s1;
	logic [COORD_BITS-1:0] col_s1, row_s1;
	logic                  done_s1;

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			rgb_s1  <= {pixel.red, pixel.green, pixel.blue};
			col_s1  <= col_q;
			row_s1  <= row_q;
			done_s1 <= img_end;
		end
	end

	// Screen position, clip test and key test. A key with bit 24 set can never
	// equal a 24-bit color, so the "keying off" code needs no separate check.
	logic signed [PW-1:0] px, py;
	logic                 inside_x, inside_y, keyed, draw;

	always_comb begin
		px       = PW'(regs.dest_x) + $signed(PW'(col_s1));
		py       = PW'(regs.dest_y) + $signed(PW'(row_s1));
		inside_x = !px[PW-1] && (px[PW-2:0] < (PW-1)'(scr_w));
		inside_y = !py[PW-1] && (py[PW-2:0] < (PW-1)'(scr_h));
		keyed    = regs.key_color == {1'b0, rgb_s1};
		draw     = inside_x && inside_y && !keyed;
	end

	// Result register. A dropped pixel carries zero coordinates and color.
	logic                  write_valid_q, image_done_q;
	logic [COORD_BITS-1:0] screen_x_q, screen_y_q;
	logic [31:0]           argb_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			write_valid_q <= draw;
			screen_x_q    <= draw ? px[COORD_BITS-1:0] : '0;
			screen_y_q    <= draw ? py[COORD_BITS-1:0] : '0;
			argb_q        <= draw ? {ALPHA_OPAQUE, rgb_s1} : '0;
			image_done_q  <= done_s1;
		end
	end

	assign blit.valid       = out_valid_q;
	assign blit.write_valid = write_valid_q;
	assign blit.screen_x    = screen_x_q;
	assign blit.screen_y    = screen_y_q;
	assign blit.argb        = argb_q;
	assign blit.image_done  = image_done_q;

	// A dropped pixel must not leak coordinates or color.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !write_valid_q) |-> (screen_x_q == '0 && screen_y_q == '0 &&
			argb_q == '0))
		else $error("dropped pixel carries nonzero payload");

	// A drawn pixel lies inside the clip rectangle.
	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && write_valid_q) |->
			(SZ_W'(screen_x_q) < scr_w && SZ_W'(screen_y_q) < scr_h))
		else $error("write request outside the framebuffer");

	// The last pixel of the image restarts both counters.
	a_counter_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_accept && img_end) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not restart after the last pixel");

	// A pixel held by a stalled result register keeps its position.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(col_s1) && $stable(row_s1)))
		else $error("pixel register changed while stalled");

	// The input side is open whenever the result register is empty.
	a_ready_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> pixel.ready)
		else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
